### hdl/hid_keyboard_report_builder_defines.svh
// assertion helpers for the keyboard report builder
`ifndef HID_KEYBOARD_REPORT_BUILDER_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_DEFINES_SVH

// same-cycle implication
`define HKRB_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// next-cycle implication
`define HKRB_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### hdl/hkrb_pkg.sv
package hkrb_pkg;

   localparam int OUT_SLOTS = 6;
   localparam int CODE_W = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = (OUT_SLOTS + 3) * CODE_W;
   localparam int RSP_USER_W = 3;

   localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;
   localparam logic [CODE_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      REG_USB_MODE = 2'd0,
      REG_KEYBOARD_ENABLE = 2'd1,
      REG_MEDIA_ENABLE = 2'd2,
      REG_MEDIA_LAYER_CODE = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_ADD_KEY = 1'b0,
      OP_END_SCAN = 1'b1
   } opcode_type;

endpackage

### hdl/hid_keyboard_report_builder.sv
// Gathers the key words of one scan and emits one boot keyboard report per scan.
// Each req word (key_word in tdata, opcode in tuser) is taken on a handshake and updates
// the modifier, media and key slot accumulators in place; an end-of-scan word loads the
// result register, and the report appears on rsp in the next cycle. One word per cycle is
// sustained: req_tready drops only while a report sits in the result register and
// rsp_tready is low. With both enables clear, words are taken and dropped. In USB mode a
// scan with more keys than SLOTS reports every slot as 0x01; slot fields at or beyond
// SLOTS read zero. Registers: usb_mode at 0x0, keyboard_enable 0x4, media_enable 0x8,
// media_layer_code 0xC.

`include "hid_keyboard_report_builder_defines.svh"

module hid_keyboard_report_builder
   import hkrb_pkg::*;
#(
   parameter int SLOTS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key_word
   input  logic                  req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // modifier_bits, media_bits, slot_0 .. slot_5, key_total
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // path_kind, keyboard_valid, media_valid
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [CODE_W-1:0] SlotsCount = CODE_W'(SLOTS);

   logic                  usb_mode_ff, usb_mode_in;
   logic                  kbd_en_ff, kbd_en_in;
   logic                  media_en_ff, media_en_in;
   logic [3:0]            layer_code_ff, layer_code_in;

   logic [CODE_W-1:0]     modifier_ff, modifier_in;
   logic [CODE_W-1:0]     media_ff, media_in;
   logic [CODE_W-1:0]     slot_ff [SLOTS];
   logic [CODE_W-1:0]     slot_in [SLOTS];
   logic [CODE_W-1:0]     count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                  csr_wr;
   reg_index_type         csr_idx;
   logic                  req_acc;
   logic                  active;
   logic                  do_add;
   logic                  do_end;
   logic [3:0]            w_layer;
   logic [3:0]            w_mod;
   logic [CODE_W-1:0]     w_code;
   logic                  is_media;
   logic [CODE_W-1:0]     mod_mask;
   logic                  overflow;
   logic [CODE_W-1:0]     out_slot [OUT_SLOTS];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         REG_USB_MODE:         csr_prdata[0] = usb_mode_ff;
         REG_KEYBOARD_ENABLE:  csr_prdata[0] = kbd_en_ff;
         REG_MEDIA_ENABLE:     csr_prdata[0] = media_en_ff;
         REG_MEDIA_LAYER_CODE: csr_prdata[3:0] = layer_code_ff;
         default:              csr_prdata = '0;
      endcase
   end

   always_comb begin
      usb_mode_in   = usb_mode_ff;
      kbd_en_in     = kbd_en_ff;
      media_en_in   = media_en_ff;
      layer_code_in = layer_code_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_USB_MODE:         usb_mode_in = csr_pwdata[0];
            REG_KEYBOARD_ENABLE:  kbd_en_in = csr_pwdata[0];
            REG_MEDIA_ENABLE:     media_en_in = csr_pwdata[0];
            REG_MEDIA_LAYER_CODE: layer_code_in = csr_pwdata[3:0];
            default:              usb_mode_in = usb_mode_ff;
         endcase
      end
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_acc    = req_tvalid & req_tready;
   assign active     = kbd_en_ff | media_en_ff;
   assign do_add     = req_acc & active & (opcode_type'(req_tuser) == OP_ADD_KEY);
   assign do_end     = req_acc & active & (opcode_type'(req_tuser) == OP_END_SCAN);

   assign w_layer  = req_tdata[15:12];
   assign w_mod    = req_tdata[11:8];
   assign w_code   = req_tdata[7:0];
   assign is_media = (w_layer == layer_code_ff);
   assign overflow = usb_mode_ff & (count_ff > SlotsCount);

   always_comb begin
      for (int b = 0; b < CODE_W; b++) begin
         mod_mask[b] = (w_mod == 4'(b + 1));
      end
   end

   always_comb begin
      for (int i = 0; i < OUT_SLOTS; i++) begin
         out_slot[i] = '0;
         if (i < SLOTS) begin
            out_slot[i] = overflow ? ROLLOVER_CODE : slot_ff[i];
         end
      end
   end

   // accumulator update; an end-of-scan word clears it
   always_comb begin
      modifier_in = modifier_ff;
      media_in    = media_ff;
      count_in    = count_ff;
      for (int s = 0; s < SLOTS; s++) begin
         slot_in[s] = slot_ff[s];
      end
      if (do_end) begin
         modifier_in = '0;
         media_in    = '0;
         count_in    = '0;
         for (int s = 0; s < SLOTS; s++) begin
            slot_in[s] = '0;
         end
      end else if (do_add) begin
         if (is_media) begin
            media_in = media_ff | w_code;
         end else begin
            modifier_in = modifier_ff | mod_mask;
            if (w_code != '0) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (count_ff == CODE_W'(s)) begin
                     slot_in[s] = w_code;
                  end
               end
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (do_end) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {count_ff, out_slot[5], out_slot[4], out_slot[3], out_slot[2],
                         out_slot[1], out_slot[0], media_ff, modifier_ff};
         rsp_user_in  = {usb_mode_ff & media_en_ff, usb_mode_ff & kbd_en_ff, usb_mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usb_mode_ff   <= 1'b1;
         kbd_en_ff     <= 1'b0;
         media_en_ff   <= 1'b0;
         layer_code_ff <= 4'h1;
         modifier_ff   <= '0;
         media_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            slot_ff[s] <= '0;
         end
      end else begin
         usb_mode_ff   <= usb_mode_in;
         kbd_en_ff     <= kbd_en_in;
         media_en_ff   <= media_en_in;
         layer_code_ff <= layer_code_in;
         modifier_ff   <= modifier_in;
         media_ff      <= media_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int s = 0; s < SLOTS; s++) begin
            slot_ff[s] <= slot_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `HKRB_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_tready, rsp_tvalid, "input stalled with empty result register")
   `HKRB_ASSERT_NEXT(a_end_gives_report, clock, reset, do_end, rsp_tvalid, "end of scan gave no report")
   `HKRB_ASSERT_NEXT(a_end_clears_acc, clock, reset, do_end, (count_ff == '0) && (modifier_ff == '0) && (media_ff == '0), "accumulator not cleared after report")
   `HKRB_ASSERT_NEXT(a_key_counted, clock, reset, do_add && !is_media && (w_code != '0), count_ff != '0, "nonzero key code not counted")

endmodule
